// File: hw/rtl/rotation_matrix_to_quaternion_top_defines.svh
// Assertion macros shared by the rotation matrix to quaternion RTL.
// The including module must provide clk and rst_n.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rmq_pkg.sv
// Package for the rotation matrix to quaternion block.
// Holds the item types, the branch code and fixed-point constants; no dependencies.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int ENTRY_W = 16;
    localparam int QUAT_W  = 16;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;
    localparam logic signed [QUAT_W-1:0] QUAT_MAX = 16'sh7fff;
    localparam logic signed [QUAT_W-1:0] QUAT_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] m00;
        logic signed [ENTRY_W-1:0] m01;
        logic signed [ENTRY_W-1:0] m02;
        logic signed [ENTRY_W-1:0] m10;
        logic signed [ENTRY_W-1:0] m11;
        logic signed [ENTRY_W-1:0] m12;
        logic signed [ENTRY_W-1:0] m20;
        logic signed [ENTRY_W-1:0] m21;
        logic signed [ENTRY_W-1:0] m22;
    } mat_item_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic                     degenerate;
        logic                     saturated;
    } quat_item_t;

    typedef enum logic [1:0] {
        LEAD_X,
        LEAD_Y,
        LEAD_Z,
        LEAD_W
    } lead_t;

endpackage

// File: hw/rtl/rmq_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; the enable advances all stages together.
`timescale 1ns / 1ps

module rmq_isqrt
#(
    parameter int XW = 32,
    parameter int RW = 16
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [XW-1:0] x,
    output logic [RW-1:0] root
);

    localparam int TW = XW + 2;

    logic [XW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        localparam int K = RW - 1 - i;
        logic [XW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [TW-1:0] trial;
        logic          take;

        if (i == 0) begin : g_first
            assign rem_in  = x;
            assign root_in = '0;
        end
        else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? rem_in - trial[XW-1:0] : rem_in;
                root_reg[i] <= take ? (root_in | (RW'(1) << K)) : root_in;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// File: hw/rtl/rmq_rdiv.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Flags a quotient that does not fit in QB bits; standalone.
`timescale 1ns / 1ps

module rmq_rdiv
#(
    parameter int NW = 29,
    parameter int DW = 16,
    parameter int QB = 13
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo,
    output logic          ovf
);

    localparam int TW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [NW-1:0] rem_reg [QB];
    logic [DW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB];
    logic          ovf_reg [QB];

    for (genvar i = 0; i < QB; i++) begin : g_stage
        localparam int K = QB - 1 - i;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] quo_in;
        logic          ovf_in;
        logic [TW-1:0] trial;
        logic          take;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign ovf_in = TW'(num) >= (TW'(den) << QB);
        end
        else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
        end

        assign trial = TW'(den_in) << K;
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? rem_in - trial[NW-1:0] : rem_in;
                den_reg[i] <= den_in;
                quo_reg[i] <= take ? (quo_in | (QB'(1) << K)) : quo_in;
                ovf_reg[i] <= ovf_in;
            end
        end
    end

    assign quo = quo_reg[QB-1];
    assign ovf = ovf_reg[QB-1];

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion_top.sv
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_isqrt, rmq_rdiv and the assertion macro header.
//
// The block takes one matrix item per clock while the output is not stalled, and
// returns its quaternion after the bit-per-stage square root and divider
// pipelines (row length root, row scaling divide, component root and
// component divide). The whole pipeline holds while a finished item waits
// in the output register under stall, and stall toward the source follows it.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mat_valid,
    output logic       mat_stall,
    input  mat_item_t  mat,
    output logic       quat_valid,
    input  logic       quat_stall,
    output quat_item_t quat,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int W    = ENTRY_W;
    localparam int MW   = (W > 14) ? W : 14;
    localparam int SQW  = 2 * W;
    localparam int QN   = 13;
    localparam int NNW  = W + 13;
    localparam int RAWD = W + QN + 2;
    localparam int ZD   = W + QN;
    localparam int AW   = MW + 2;
    localparam int DDW  = MW + 1;
    localparam int XW   = MW + 29;
    localparam int RW   = (XW + 1) / 2;
    localparam int DNW  = MW + 23;
    localparam int QB   = 17;
    localparam int LVW  = RW - 6;
    localparam int VN   = W + QN + 6 + RW + QB;

    logic adv;
    logic norm_reg;
    logic vld_reg [VN];
    logic quat_valid_reg;
    quat_item_t quat_item_reg;
    quat_item_t res_next;

    assign adv       = !quat_valid_reg || !quat_stall;
    assign mat_stall = !adv;
    assign cfg_ready = 1'b1;
    assign quat_valid = quat_valid_reg;
    assign quat       = quat_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            norm_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VN; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            quat_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= mat_valid;
            for (int k = 1; k < VN; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            quat_valid_reg <= vld_reg[VN-1];
        end
    end

    // Row normalization section.
    logic signed [W-1:0] m_in    [9];
    logic signed [W-1:0] m0_reg  [9];
    logic [W-1:0]        abs0    [9];
    logic [SQW-1:0]      sq1_reg [9];
    logic [SQW-1:0]      rs2_reg [3];
    logic                zero2_reg [3];
    logic [W-1:0]        len     [3];
    logic signed [W-1:0] mdly_reg [RAWD][9];
    logic                zdly_reg [ZD][3];
    logic [QN-1:0]       nq      [9];
    logic                novf    [9];

    assign m_in[0] = mat.m00;
    assign m_in[1] = mat.m01;
    assign m_in[2] = mat.m02;
    assign m_in[3] = mat.m10;
    assign m_in[4] = mat.m11;
    assign m_in[5] = mat.m12;
    assign m_in[6] = mat.m20;
    assign m_in[7] = mat.m21;
    assign m_in[8] = mat.m22;

    for (genvar i = 0; i < 9; i++) begin : g_abs
        assign abs0[i] = m0_reg[i][W-1] ? W'(-m0_reg[i]) : W'(m0_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg <= m_in;
            for (int i = 0; i < 9; i++)
            begin
                sq1_reg[i] <= abs0[i] * abs0[i];
            end
            for (int r = 0; r < 3; r++)
            begin
                rs2_reg[r]   <= sq1_reg[3*r] + sq1_reg[3*r+1] + sq1_reg[3*r+2];
                zero2_reg[r] <= (sq1_reg[3*r] | sq1_reg[3*r+1] | sq1_reg[3*r+2]) == '0;
            end
            mdly_reg[0] <= m0_reg;
            for (int k = 1; k < RAWD; k++)
            begin
                mdly_reg[k] <= mdly_reg[k-1];
            end
            zdly_reg[0] <= zero2_reg;
            for (int k = 1; k < ZD; k++)
            begin
                zdly_reg[k] <= zdly_reg[k-1];
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row_root
        rmq_isqrt #(
            .XW (SQW),
            .RW (W)
        ) u_len (
            .clk  (clk),
            .en   (adv),
            .x    (rs2_reg[r]),
            .root (len[r])
        );
    end

    for (genvar i = 0; i < 9; i++) begin : g_row_div
        logic signed [W-1:0] tap;
        logic [W-1:0]        mag;
        logic [NNW-1:0]      num;

        assign tap = mdly_reg[W+1][i];
        assign mag = tap[W-1] ? W'(-tap) : W'(tap);
        assign num = (NNW'(mag) << 12) + NNW'(len[i/3] >> 1);

        rmq_rdiv #(
            .NW (NNW),
            .DW (W),
            .QB (QN)
        ) u_scale (
            .clk (clk),
            .en  (adv),
            .num (num),
            .den (len[i/3]),
            .quo (nq[i]),
            .ovf (novf[i])
        );
    end

    // Branch selection section.
    logic signed [MW-1:0]  msel_reg [9];
    logic                  zdeg1_reg;
    logic signed [W-1:0]   mraw [9];
    logic                  t_nonneg2_reg;
    logic                  xgt2_reg;
    logic                  ygt2_reg;
    logic signed [AW-1:0]  argw2_reg;
    logic signed [AW-1:0]  argx2_reg;
    logic signed [AW-1:0]  argy2_reg;
    logic signed [AW-1:0]  argz2_reg;
    logic signed [DDW-1:0] p71_2_reg;
    logic signed [DDW-1:0] p31_2_reg;
    logic signed [DDW-1:0] p26_2_reg;
    logic signed [DDW-1:0] q26_2_reg;
    logic signed [DDW-1:0] p75_2_reg;
    logic signed [DDW-1:0] q31_2_reg;
    logic                  zdeg2_reg;
    logic signed [AW-1:0]  tsum;
    lead_t                 lead_next;
    logic signed [AW-1:0]  arg_next;
    logic signed [DDW-1:0] d_next [3];
    lead_t                 lead3_reg;
    logic signed [AW-1:0]  arg3_reg;
    logic signed [DDW-1:0] d3_reg [3];
    logic                  degen3_reg;

    assign mraw = mdly_reg[RAWD-1];
    assign tsum = AW'(msel_reg[0]) + AW'(msel_reg[4]) + AW'(msel_reg[8]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                if (!norm_reg || novf[i])
                begin
                    msel_reg[i] <= MW'(mraw[i]);
                end
                else if (mraw[i][W-1])
                begin
                    msel_reg[i] <= MW'(0) - MW'(nq[i]);
                end
                else
                begin
                    msel_reg[i] <= MW'(nq[i]);
                end
            end
            zdeg1_reg <= norm_reg && (zdly_reg[ZD-1][0] || zdly_reg[ZD-1][1] ||
                                      zdly_reg[ZD-1][2]);

            t_nonneg2_reg <= tsum >= 0;
            xgt2_reg <= (msel_reg[0] > msel_reg[4]) && (msel_reg[0] > msel_reg[8]);
            ygt2_reg <= msel_reg[4] > msel_reg[8];
            argw2_reg <= tsum + AW'(4096);
            argx2_reg <= AW'(4096) + AW'(msel_reg[0]) - AW'(msel_reg[4]) - AW'(msel_reg[8]);
            argy2_reg <= AW'(4096) + AW'(msel_reg[4]) - AW'(msel_reg[0]) - AW'(msel_reg[8]);
            argz2_reg <= AW'(4096) + AW'(msel_reg[8]) - AW'(msel_reg[0]) - AW'(msel_reg[4]);
            p71_2_reg <= DDW'(msel_reg[7]) - DDW'(msel_reg[5]);
            p31_2_reg <= DDW'(msel_reg[3]) + DDW'(msel_reg[1]);
            p26_2_reg <= DDW'(msel_reg[2]) + DDW'(msel_reg[6]);
            q26_2_reg <= DDW'(msel_reg[2]) - DDW'(msel_reg[6]);
            p75_2_reg <= DDW'(msel_reg[7]) + DDW'(msel_reg[5]);
            q31_2_reg <= DDW'(msel_reg[3]) - DDW'(msel_reg[1]);
            zdeg2_reg <= zdeg1_reg;

            lead3_reg  <= lead_next;
            arg3_reg   <= arg_next;
            d3_reg     <= d_next;
            degen3_reg <= zdeg2_reg || (arg_next <= 0);
        end
    end

    always_comb
    begin
        if (t_nonneg2_reg)
        begin
            lead_next = LEAD_W;
            arg_next  = argw2_reg;
            d_next[0] = p71_2_reg;
            d_next[1] = q26_2_reg;
            d_next[2] = q31_2_reg;
        end
        else if (xgt2_reg)
        begin
            lead_next = LEAD_X;
            arg_next  = argx2_reg;
            d_next[0] = p31_2_reg;
            d_next[1] = p26_2_reg;
            d_next[2] = p71_2_reg;
        end
        else if (ygt2_reg)
        begin
            lead_next = LEAD_Y;
            arg_next  = argy2_reg;
            d_next[0] = p31_2_reg;
            d_next[1] = p75_2_reg;
            d_next[2] = q26_2_reg;
        end
        else
        begin
            lead_next = LEAD_Z;
            arg_next  = argz2_reg;
            d_next[0] = p26_2_reg;
            d_next[1] = p75_2_reg;
            d_next[2] = q31_2_reg;
        end
    end

    // Component root and divide section.
    logic [XW-1:0]         root_arg;
    logic [RW-1:0]         r_root;
    logic signed [DDW-1:0] ddly_reg [RW][3];
    lead_t                 ldly_reg [RW];
    logic                  gdly_reg [RW];
    logic [RW:0]           lv_full;
    logic [LVW-1:0]        lv;
    logic [LVW-1:0]        lvdly_reg [QB];
    logic                  sdly_reg  [QB][3];
    lead_t                 l2dly_reg [QB];
    logic                  g2dly_reg [QB];
    logic [QB-1:0]         cq   [3];
    logic                  covf [3];

    assign root_arg = degen3_reg ? '0 : (XW'(arg3_reg[MW:0]) << 28);

    rmq_isqrt #(
        .XW (XW),
        .RW (RW)
    ) u_root (
        .clk  (clk),
        .en   (adv),
        .x    (root_arg),
        .root (r_root)
    );

    assign lv_full = ({1'b0, r_root} + (RW+1)'(64)) >> 7;
    assign lv      = lv_full[LVW-1:0];

    for (genvar c = 0; c < 3; c++) begin : g_comp_div
        logic signed [DDW-1:0] dv;
        logic [DDW-1:0]        mag;
        logic [DNW-1:0]        num;

        assign dv  = ddly_reg[RW-1][c];
        assign mag = dv[DDW-1] ? DDW'(-dv) : DDW'(dv);
        assign num = (DNW'(mag) << 21) + DNW'(r_root >> 1);

        rmq_rdiv #(
            .NW (DNW),
            .DW (RW),
            .QB (QB)
        ) u_comp (
            .clk (clk),
            .en  (adv),
            .num (num),
            .den (r_root),
            .quo (cq[c]),
            .ovf (covf[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ddly_reg[0] <= d3_reg;
            ldly_reg[0] <= lead3_reg;
            gdly_reg[0] <= degen3_reg;
            for (int k = 1; k < RW; k++)
            begin
                ddly_reg[k] <= ddly_reg[k-1];
                ldly_reg[k] <= ldly_reg[k-1];
                gdly_reg[k] <= gdly_reg[k-1];
            end
            lvdly_reg[0] <= lv;
            for (int c = 0; c < 3; c++)
            begin
                sdly_reg[0][c] <= ddly_reg[RW-1][c][DDW-1];
            end
            l2dly_reg[0] <= ldly_reg[RW-1];
            g2dly_reg[0] <= gdly_reg[RW-1];
            for (int k = 1; k < QB; k++)
            begin
                lvdly_reg[k] <= lvdly_reg[k-1];
                sdly_reg[k]  <= sdly_reg[k-1];
                l2dly_reg[k] <= l2dly_reg[k-1];
                g2dly_reg[k] <= g2dly_reg[k-1];
            end
            quat_item_reg <= res_next;
        end
    end

    function automatic logic [QUAT_W:0] clip_div(input logic neg, input logic [QB-1:0] q,
                                                 input logic ovf);
        logic [QUAT_W:0] res;
        if (!neg)
        begin
            if (ovf || q > QB'(32767))
            begin
                res = {1'b1, QUAT_MAX};
            end
            else
            begin
                res = {1'b0, q[QUAT_W-1:0]};
            end
        end
        else
        begin
            if (ovf || q > QB'(32768))
            begin
                res = {1'b1, QUAT_MIN};
            end
            else
            begin
                res = {1'b0, QUAT_W'(QB'(0) - q)};
            end
        end
        return res;
    endfunction

    logic [QUAT_W:0] ca;
    logic [QUAT_W:0] cb;
    logic [QUAT_W:0] cc;
    logic [QUAT_W:0] cl;

    assign ca = clip_div(sdly_reg[QB-1][0], cq[0], covf[0]);
    assign cb = clip_div(sdly_reg[QB-1][1], cq[1], covf[1]);
    assign cc = clip_div(sdly_reg[QB-1][2], cq[2], covf[2]);
    assign cl = (lvdly_reg[QB-1] > LVW'(32767)) ? {1'b1, QUAT_MAX}
                                                : {1'b0, lvdly_reg[QB-1][QUAT_W-1:0]};

    always_comb
    begin
        res_next.degenerate = g2dly_reg[QB-1];
        res_next.saturated  = ca[QUAT_W] | cb[QUAT_W] | cc[QUAT_W] | cl[QUAT_W];
        unique case (l2dly_reg[QB-1])
            LEAD_W:
            begin
                res_next.quat_w = cl[QUAT_W-1:0];
                res_next.quat_x = ca[QUAT_W-1:0];
                res_next.quat_y = cb[QUAT_W-1:0];
                res_next.quat_z = cc[QUAT_W-1:0];
            end
            LEAD_X:
            begin
                res_next.quat_x = cl[QUAT_W-1:0];
                res_next.quat_y = ca[QUAT_W-1:0];
                res_next.quat_z = cb[QUAT_W-1:0];
                res_next.quat_w = cc[QUAT_W-1:0];
            end
            LEAD_Y:
            begin
                res_next.quat_y = cl[QUAT_W-1:0];
                res_next.quat_x = ca[QUAT_W-1:0];
                res_next.quat_z = cb[QUAT_W-1:0];
                res_next.quat_w = cc[QUAT_W-1:0];
            end
            default:
            begin
                res_next.quat_z = cl[QUAT_W-1:0];
                res_next.quat_x = ca[QUAT_W-1:0];
                res_next.quat_y = cb[QUAT_W-1:0];
                res_next.quat_w = cc[QUAT_W-1:0];
            end
        endcase
        if (g2dly_reg[QB-1])
        begin
            res_next.quat_x    = '0;
            res_next.quat_y    = '0;
            res_next.quat_z    = '0;
            res_next.quat_w    = QUAT_ONE;
            res_next.saturated = 1'b0;
        end
    end

    // A degenerate item always carries the identity quaternion without clipping.
    `RMQ_ASSERT_IMP(a_degen_identity, quat_valid_reg && quat_item_reg.degenerate,
        quat_item_reg.quat_x == 0 && quat_item_reg.quat_y == 0 &&
        quat_item_reg.quat_z == 0 && quat_item_reg.quat_w == QUAT_ONE &&
        !quat_item_reg.saturated, "degenerate item is not the identity")

    // Any clip leaves at least one component at a range limit.
    `RMQ_ASSERT_IMP(a_sat_at_limit, quat_valid_reg && quat_item_reg.saturated,
        quat_item_reg.quat_x == QUAT_MAX || quat_item_reg.quat_x == QUAT_MIN ||
        quat_item_reg.quat_y == QUAT_MAX || quat_item_reg.quat_y == QUAT_MIN ||
        quat_item_reg.quat_z == QUAT_MAX || quat_item_reg.quat_z == QUAT_MIN ||
        quat_item_reg.quat_w == QUAT_MAX || quat_item_reg.quat_w == QUAT_MIN,
        "saturated flag without a clipped component")

    // A regular item always has at least one positive component.
    `RMQ_ASSERT_IMP(a_lead_positive, quat_valid_reg && !quat_item_reg.degenerate,
        quat_item_reg.quat_x > 0 || quat_item_reg.quat_y > 0 ||
        quat_item_reg.quat_z > 0 || quat_item_reg.quat_w > 0,
        "regular item has no positive component")

    // While the output is held, the last pipeline stage keeps its item.
    `RMQ_ASSERT_NEXT(a_pipe_hold, quat_valid_reg && quat_stall,
        vld_reg[VN-1] == $past(vld_reg[VN-1]), "pipeline moved while output stalled")

endmodule
